// ===== rtl/core/linear_probe_hash_table_macros.svh =====
// Assertion macros for the hash table RTL, used by lpht_ctrl.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lpht_pkg.sv =====
// Shared types and codes for the linear probing hash table.
// No dependencies; imported by every module of the block but lpht_ram.
`default_nettype none

package lpht_pkg;

    localparam int KEY_W      = 31;
    localparam int VALUE_W    = 32;
    localparam int SLOT_IDX_W = 10;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_entry_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_W-1:0]    found_value;
        logic [SLOT_IDX_W-1:0] slot_index;
    } lpht_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpht_ram.sv =====
// Single-port-write, single-port-read synchronous RAM holding the slot entries.
// Read data is registered and updated only while re is high. Depends on nothing.
`default_nettype none

module lpht_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_mod.sv =====
// Home slot unit: key modulo the slot count.
// A mask for a power-of-two count, else a reciprocal multiply, then a subtraction.
// Depends on lpht_pkg.
`default_nettype none

module lpht_mod
    import lpht_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [KEY_W-1:0]         key,
    output      logic                     done,
    output      logic [$clog2(SLOTS)-1:0] rem
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int SHIFT   = KEY_W + IDX_W;
    localparam int PROD_W  = 2 * KEY_W + 1;
    // The rounded-up reciprocal gives an exact quotient for every key of KEY_W bits.
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + SLOTS - 1) / SLOTS;
    localparam logic [KEY_W:0]     RECIP     = (KEY_W + 1)'(RECIP_L);
    localparam logic [IDX_W-1:0]   SLOTS_LOW = IDX_W'(SLOTS);

    logic              stage_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [KEY_W-1:0]  quot;
    logic [IDX_W-1:0]  quot_low_prod;

    // The remainder is below SLOTS, so only the low index bits of the product matter.
    assign quot          = KEY_W'(prod_reg >> SHIFT);
    assign quot_low_prod = quot[IDX_W-1:0] * SLOTS_LOW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
            key_reg   <= '0;
            prod_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            done_reg  <= (start && IS_POW2) || stage_reg;
            stage_reg <= start && !IS_POW2;
            if (start)
            begin
                key_reg  <= key;
                prod_reg <= key * RECIP;
                rem_reg  <= key[IDX_W-1:0];
            end
            else if (stage_reg)
            begin
                rem_reg <= key_reg[IDX_W-1:0] - quot_low_prod;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_ctrl.sv =====
// Probe sequencer: clears the slot RAM after reset, then runs one request at a time,
// reading one slot per cycle and writing back on insert or delete.
// Depends on lpht_pkg and linear_probe_hash_table_macros.svh.
`default_nettype none
`include "linear_probe_hash_table_macros.svh"

module lpht_ctrl
    import lpht_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic [1:0]               in_action,
    input  wire logic [KEY_W-1:0]         in_key,
    input  wire logic [VALUE_W-1:0]       in_value,
    output      logic                     mod_start,
    input  wire logic                     mod_done,
    input  wire logic [$clog2(SLOTS)-1:0] mod_rem,
    output      logic                     mem_we,
    output      logic [$clog2(SLOTS)-1:0] mem_waddr,
    output      slot_entry_t              mem_wdata,
    output      logic                     mem_re,
    output      logic [$clog2(SLOTS)-1:0] mem_raddr,
    input  wire slot_entry_t              mem_rdata,
    output      logic                     res_valid,
    input  wire logic                     res_ready,
    output      lpht_result_t             res
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   clr_reg;
    lpht_result_t       res_reg;

    logic               accept;
    logic               hit;
    logic               empty;
    logic               lap_end;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W+SLOT_IDX_W-1:0] idx_ext;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign hit      = mem_rdata.used && (mem_rdata.key == key_reg);
    assign empty    = !mem_rdata.used;
    assign lap_end  = (cnt_reg == LAST_IDX);
    assign idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign idx_ext  = {{SLOT_IDX_W{1'b0}}, idx_reg};

    assign mod_start = accept && (in_action == ACT_INSERT || in_action == ACT_LOOKUP
                                  || in_action == ACT_DELETE);

    // Memory port control. Writes happen only in the clearing pass and when a probe ends.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = idx_next;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_HASH:
            begin
                mem_re    = mod_done;
                mem_raddr = mod_rem;
            end
            ST_CHECK:
            begin
                if (act_reg == ACT_INSERT && (hit || empty))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{used: 1'b1, key: key_reg, value: val_reg};
                end
                else if (act_reg == ACT_DELETE && hit)
                begin
                    mem_we = 1'b1;
                end
                else if (!hit && !empty && !lap_end)
                begin
                    mem_re = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            act_reg   <= '0;
            key_reg   <= '0;
            val_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg <= in_action;
                        key_reg <= in_key;
                        val_reg <= in_value;
                        res_reg <= '{status: STATUS_NOT_FOUND, default: '0};
                        if (mod_start)
                        begin
                            state_reg <= ST_HASH;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_HASH:
                begin
                    if (mod_done)
                    begin
                        idx_reg   <= mod_rem;
                        cnt_reg   <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (hit || (empty && act_reg == ACT_INSERT))
                    begin
                        res_reg.status     <= STATUS_OK;
                        res_reg.slot_index <= idx_ext[SLOT_IDX_W-1:0];
                        if (act_reg == ACT_LOOKUP)
                        begin
                            res_reg.found_value <= mem_rdata.value;
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (empty)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (lap_end)
                    begin
                        if (act_reg == ACT_INSERT)
                        begin
                            res_reg.status <= STATUS_FULL;
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_next;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    `LPHT_ASSERT_IMPL(a_no_rw_same_slot, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same slot")
    `LPHT_ASSERT_IMPL(a_no_write_when_ready, in_ready, !mem_we, "slot RAM written while taking a request")
    `LPHT_ASSERT_NEXT(a_hash_to_probe, state_reg == ST_HASH && mod_done, state_reg == ST_CHECK, "home slot ready but no probe started")
    `LPHT_ASSERT_NEXT(a_write_ends_probe, state_reg == ST_CHECK && mem_we, state_reg == ST_DONE, "probe continued after writing a slot")

endmodule

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// Linear probing hash table: a slot RAM holding used flag, key and value for each slot.
// Requests arrive on the s_axis channel: tuser[1:0] is the action (insert, lookup,
// delete, or an unused code answered as not found); tdata holds key then value.
// Each request produces exactly one transfer on m_axis: tuser[1:0] is the status
// (done/found, not found, full), tdata holds the found value then the slot index.
// The home slot is the key modulo SLOTS: a mask when SLOTS is a power of two,
// otherwise a reciprocal multiplication in the remainder unit. Probing then reads
// one slot per cycle from the RAM; a request visits P slots, where P is 1 in a
// sparse table and up to SLOTS in a full one. One request is processed at a time;
// s_axis_tready rises again the cycle after the result moves into the output
// register.
// After reset the RAM is swept clear, one slot per cycle, from the first slot to
// the last; s_axis_tready stays low meanwhile.
// If m_axis_tready is low, the result holds in the output register and one more
// request may be completed behind it before the input side stalls.
// Depends on lpht_pkg, lpht_mod, lpht_ram and lpht_ctrl.
`default_nettype none

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // search_key[30:0], entry_value[62:31], zero
    input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [47:0] m_axis_tdata,  // found_value[31:0], slot_index[41:32], zero
    output      logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int IDX_W = $clog2(SLOTS);

    logic             mod_start;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    slot_entry_t      mem_rdata;
    logic             res_valid;
    logic             res_ready;
    lpht_result_t     res;

    logic             out_valid_reg;
    lpht_result_t     out_reg;

    lpht_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (s_axis_tdata[KEY_W-1:0]),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    lpht_ram #(
        .DEPTH (SLOTS),
        .WIDTH ($bits(slot_entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lpht_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_key    (s_axis_tdata[KEY_W-1:0]),
        .in_value  (s_axis_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .mod_start (mod_start),
        .mod_done  (mod_done),
        .mod_rem   (mod_rem),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
                if (res_valid)
                begin
                    out_reg <= res;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {6'b0, out_reg.slot_index, out_reg.found_value};

endmodule

`default_nettype wire

// ===== tb/lpht_result_checker.sv =====
// Checker for the linear probing hash table: watches both stream channels, keeps its
// own copy of the slot store and compares each result transfer with the predicted one.
// Depends on lpht_pkg for the field widths, action and status codes.
module lpht_result_checker
    import lpht_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    output int               pending,
    output int               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    bit                 occupied     [SLOTS];
    logic [KEY_W-1:0]   stored_key   [SLOTS];
    logic [VALUE_W-1:0] stored_value [SLOTS];

    lpht_result_t awaited_results[$];
    lpht_result_t observed;
    lpht_result_t predicted;

    // Runs one request against the local table and returns the result it must produce.
    function automatic lpht_result_t apply_request(input logic [1:0]         act,
                                                   input logic [KEY_W-1:0]   key,
                                                   input logic [VALUE_W-1:0] value);
        lpht_result_t res;
        int unsigned  pos;
        int unsigned  step;
        bit           hit;
        bit           empty_seen;
        res.status      = STATUS_NOT_FOUND;
        res.found_value = '0;
        res.slot_index  = '0;
        hit             = 1'b0;
        empty_seen      = 1'b0;
        pos             = key % SLOTS;
        for (step = 0; step < SLOTS; step++)
        begin
            if (!occupied[pos])
            begin
                empty_seen = 1'b1;
                break;
            end
            if (stored_key[pos] == key)
            begin
                hit = 1'b1;
                break;
            end
            pos = (pos + 1) % SLOTS;
        end
        case (act)
            ACT_INSERT:
            begin
                if (hit || empty_seen)
                begin
                    occupied[pos]     = 1'b1;
                    stored_key[pos]   = key;
                    stored_value[pos] = value;
                    res.status        = STATUS_OK;
                    res.slot_index    = SLOT_IDX_W'(pos);
                end
                else
                begin
                    res.status = STATUS_FULL;
                end
            end
            ACT_LOOKUP:
            begin
                if (hit)
                begin
                    res.status      = STATUS_OK;
                    res.found_value = stored_value[pos];
                    res.slot_index  = SLOT_IDX_W'(pos);
                end
            end
            ACT_DELETE:
            begin
                // No tombstone is left behind, so later probes stop at this slot.
                if (hit)
                begin
                    occupied[pos]  = 1'b0;
                    res.status     = STATUS_OK;
                    res.slot_index = SLOT_IDX_W'(pos);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.status      = m_axis_tuser;
                observed.found_value = m_axis_tdata[VALUE_W-1:0];
                observed.slot_index  = m_axis_tdata[VALUE_W+SLOT_IDX_W-1:VALUE_W];
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result transfer with nothing outstanding: status %0d value %h slot %0d",
                                 $time, observed.status, observed.found_value,
                                 observed.slot_index);
                end
                else
                begin
                    predicted = awaited_results.pop_front();
                    if (observed.status != predicted.status
                        || observed.found_value != predicted.found_value
                        || observed.slot_index != predicted.slot_index)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: result mismatch: status %0d/%0d value %h/%h slot %0d/%0d (expected/actual)",
                                     $time, predicted.status, observed.status,
                                     predicted.found_value, observed.found_value,
                                     predicted.slot_index, observed.slot_index);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(apply_request(s_axis_tuser,
                                                        s_axis_tdata[KEY_W-1:0],
                                                        s_axis_tdata[KEY_W+VALUE_W-1:KEY_W]));
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
// Top of the hash table testbench: clock, reset, request stimulus, result-side stalls,
// a stall watchdog and the verdict. Depends on lpht_pkg, the block and lpht_result_checker.
module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int         TABLE_SLOTS  = 1024;
    localparam int         IDLE_PERCENT = 34;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         DRAIN_CYCLES = TABLE_SLOTS + 16;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int pending;
    int mismatches;
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    logic [KEY_W-1:0] cluster_keys[$];
    logic [KEY_W-1:0] fill_keys[$];

    linear_probe_hash_table #(
        .SLOTS(TABLE_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    lpht_result_checker #(
        .SLOTS(TABLE_SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [1:0]         act,
                                input logic [KEY_W-1:0]   key,
                                input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, value, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [1:0] pick_action();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return ACT_INSERT;
        if (roll < 75)
            return ACT_LOOKUP;
        if (roll < 95)
            return ACT_DELETE;
        return ACT_UNUSED;
    endfunction

    // Keys homed in a narrow window that straddles the wrap from the last slot to slot 0,
    // so that clusters form, collide and wrap around.
    function automatic logic [KEY_W-1:0] pick_cluster_key();
        logic [SLOT_IDX_W-1:0] home;
        logic [KEY_W-1:0]      key;
        if (cluster_keys.size() != 0 && $urandom_range(0, 99) < 65)
            return cluster_keys[$urandom_range(0, cluster_keys.size() - 1)];
        home = SLOT_IDX_W'(($urandom_range(0, 127) + TABLE_SLOTS - 64) % TABLE_SLOTS);
        key  = {(KEY_W - SLOT_IDX_W)'($urandom), home};
        cluster_keys.push_back(key);
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] pick_fill_key();
        if (fill_keys.size() != 0 && $urandom_range(0, 1) != 0)
            return fill_keys[$urandom_range(0, fill_keys.size() - 1)];
        return KEY_W'($urandom);
    endfunction

    initial
    begin
        logic [KEY_W-1:0] key;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme keys and values, collisions at slot 0 and at the wrap,
        // replacement, absent keys, the unused action and the lack of tombstones.
        send_request(ACT_INSERT, 31'd0, 32'h0000_0000);
        send_request(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 31'd1024, 32'h1234_5678);
        send_request(ACT_INSERT, 31'd2047, 32'h8000_0001);
        send_request(ACT_LOOKUP, 31'd2047, 32'hFFFF_FFFF);
        send_request(ACT_LOOKUP, 31'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_LOOKUP, 31'd0, 32'hDEAD_BEEF);
        send_request(ACT_INSERT, 31'd1024, 32'hCAFE_F00D);
        send_request(ACT_LOOKUP, 31'd1024, 32'h0000_0000);
        send_request(ACT_LOOKUP, 31'd3072, 32'h0000_0000);
        send_request(ACT_DELETE, 31'd5, 32'hFFFF_FFFF);
        send_request(ACT_UNUSED, 31'd1024, 32'hFFFF_FFFF);
        send_request(ACT_LOOKUP, 31'd1024, 32'h0000_0000);
        send_request(ACT_DELETE, 31'd0, 32'h0000_0000);
        send_request(ACT_LOOKUP, 31'd1024, 32'h0000_0000);
        send_request(ACT_LOOKUP, 31'd2047, 32'h0000_0000);
        send_request(ACT_INSERT, 31'd2047, 32'h7FFF_FFFE);
        send_request(ACT_DELETE, 31'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_DELETE, 31'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
        send_request(ACT_LOOKUP, 31'h5555_5555, 32'h5555_5555);
        send_request(ACT_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);

        // Mixed traffic on crowded clusters; the first part runs without any idling.
        steady = 1'b1;
        for (int i = 0; i < 450; i++)
        begin
            if (i == 250)
                steady = 1'b0;
            send_request(pick_action(), pick_cluster_key(), $urandom);
        end

        // Fill the table well past its capacity so that inserts start to report full.
        for (int i = 0; i < 1100; i++)
        begin
            key = KEY_W'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(ACT_LOOKUP, key, $urandom);
            end
            else
            begin
                fill_keys.push_back(key);
                send_request(ACT_INSERT, key, $urandom);
            end
        end

        // Traffic on a full table: full laps, replacements, and holes that get refilled.
        for (int i = 0; i < 180; i++)
            send_request(pick_action(), pick_fill_key(), $urandom);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
